FILE: hw/rtl/fud_pkg.sv
// Package with the types, character constants and drive-letter helpers of the file URI decoder.
`timescale 1ns / 1ps

package fud_pkg;

  localparam int unsigned MaxRes = 6;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [2:0] PrefixLastPos = 3'd6;

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_DECODE  = 2'd1,
    PH_DISCARD = 2'd2
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [7:0] path_byte;
    logic       byte_valid;
    logic       path_end;
    logic       rejected;
  } res_t;

  // Drive-letter recognizer state. The held '/' and ':' are known, so only the letter is kept.
  typedef struct packed {
    logic [7:0] letter;
    logic [1:0] la_cnt;
    logic       done;
    logic       zero;
  } drv_t;

  // Up to four bytes that one decoded byte releases, plus the new recognizer state.
  typedef struct packed {
    drv_t            st;
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } feed_t;

  function automatic logic [7:0] scheme_char(logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h66; // f
      3'd1:    c = 8'h69; // i
      3'd2:    c = 8'h6C; // l
      3'd3:    c = 8'h65; // e
      3'd4:    c = ChColon;
      3'd5:    c = ChSlash;
      3'd6:    c = ChSlash;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
  endfunction

  // Bit 4 set when the character is a hex digit, low nibble its value.
  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v  = c - 8'h30;
      ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v  = c - 8'h57;
      ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v  = c - 8'h37;
      ok = 1'b1;
    end
    return {ok, v[3:0]};
  endfunction

  // Settles the drive-letter decision at the end of the path.
  function automatic feed_t drv_finish(drv_t st);
    feed_t r;
    r.st = st;
    r.b  = '0;
    r.n  = 3'd0;
    if (!st.done) begin
      case (st.la_cnt)
        2'd3: begin
          r.b[0] = to_lower(st.letter);
          r.b[1] = ChColon;
          r.n    = 3'd2;
        end
        2'd2: begin
          r.b[0] = ChSlash;
          r.b[1] = st.letter;
          r.n    = 3'd2;
        end
        2'd1: begin
          r.b[0] = ChSlash;
          r.n    = 3'd1;
        end
        default: r.n = 3'd0;
      endcase
      r.st.la_cnt = 2'd0;
      r.st.done   = 1'b1;
    end
    return r;
  endfunction

  // Passes one decoded byte through the drive-letter recognizer.
  function automatic feed_t drv_feed(drv_t st, logic [7:0] d);
    feed_t r;
    logic  ok;
    r.st = st;
    r.b  = '0;
    r.n  = 3'd0;
    ok   = ((st.la_cnt == 2'd0) && (d == ChSlash)) ||
           ((st.la_cnt == 2'd1) && is_letter(d)) ||
           ((st.la_cnt == 2'd2) && (d == ChColon));
    if (st.zero) begin
      r.n = 3'd0;
    end else if (d == 8'h00) begin
      r         = drv_finish(st);
      r.st.zero = 1'b1;
    end else if (st.done) begin
      r.b[0] = d;
      r.n    = 3'd1;
    end else if (st.la_cnt == 2'd3) begin
      if (d == ChSlash) begin
        r.b[0] = to_lower(st.letter);
        r.b[1] = ChColon;
        r.b[2] = d;
        r.n    = 3'd3;
      end else begin
        r.b[0] = ChSlash;
        r.b[1] = st.letter;
        r.b[2] = ChColon;
        r.b[3] = d;
        r.n    = 3'd4;
      end
      r.st.la_cnt = 2'd0;
      r.st.done   = 1'b1;
    end else if (ok) begin
      if (st.la_cnt == 2'd1) begin
        r.st.letter = d;
      end
      r.st.la_cnt = st.la_cnt + 2'd1;
    end else begin
      case (st.la_cnt)
        2'd2: begin
          r.b[0] = ChSlash;
          r.b[1] = st.letter;
          r.b[2] = d;
          r.n    = 3'd3;
        end
        2'd1: begin
          r.b[0] = ChSlash;
          r.b[1] = d;
          r.n    = 3'd2;
        end
        default: begin
          r.b[0] = d;
          r.n    = 3'd1;
        end
      endcase
      r.st.la_cnt = 2'd0;
      r.st.done   = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/file_uri_to_path_decoder.sv
// Top level of the file URI to path decoder: input register, decode logic and result burst buffer.
`timescale 1ns / 1ps

// Takes a file:// URI one byte per transfer (tlast on its final byte) and returns the decoded path
// one byte per transfer, with tlast on the final result of each URI. A URI that does not start
// with file:// gives a single result with the rejected flag set; an empty path gives a single
// result with byte_valid clear. Each accepted byte is registered, then decoded into up to six
// results that load a burst buffer draining one result per cycle while the output is ready. A
// new byte is taken every cycle as long as each byte yields at most one result and the output
// is not stalled; a byte that yields more (escape failures, drive-letter release) stalls the input
// while the single output port drains them. A byte passes the input register, then the buffer.
module file_uri_to_path_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] path_byte
  output logic [1:0] m_axis_tuser_o,   // [0] byte_valid, [1] rejected
  output logic       m_axis_tlast_o    // path_end
);

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Decoder state.
  fud_pkg::phase_e phase_q, phase_d;
  logic [2:0]      pos_q, pos_d;
  logic [1:0]      held_q, held_d;
  logic [7:0]      digit_q, digit_d;
  fud_pkg::drv_t   drv_q, drv_d;

  // Result burst buffer.
  fud_pkg::res_t   res_q [fud_pkg::MaxRes];
  fud_pkg::res_t   res_d [fud_pkg::MaxRes];
  logic [2:0]      cnt_q, res_n;

  logic adv;
  logic out_xfer;
  logic prefix_match;
  logic path_done;

  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;
  assign adv             = in_vld_q && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_axis_tready_i));
  assign s_axis_tready_o = !in_vld_q || adv;
  assign prefix_match    = (in_byte_q == fud_pkg::scheme_char(pos_q));

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tdata_o  = res_q[0].path_byte;
  assign m_axis_tuser_o  = {res_q[0].rejected, res_q[0].byte_valid};
  assign m_axis_tlast_o  = res_q[0].path_end;

  // Decode datapath: works out every result of the registered byte at once.
  always_comb begin
    logic [2:0][7:0] fl;
    logic [1:0]      nf;
    logic [4:0]      h;
    logic [4:0]      hd;
    fud_pkg::feed_t  fo;
    fud_pkg::drv_t   drv;
    logic [2:0]      n;

    for (int i = 0; i < fud_pkg::MaxRes; i++) begin
      res_d[i] = '0;
    end
    fl        = '0;
    nf        = 2'd0;
    h         = fud_pkg::hex_of(in_byte_q);
    hd        = fud_pkg::hex_of(digit_q);
    fo        = '0;
    drv       = drv_q;
    n         = 3'd0;
    pos_d     = pos_q;
    held_d    = held_q;
    digit_d   = digit_q;
    path_done = 1'b0;

    unique case (phase_q)
      fud_pkg::PH_PREFIX: begin
        if (prefix_match) begin
          if (pos_q == fud_pkg::PrefixLastPos) begin
            pos_d  = 3'd0;
            held_d = 2'd0;
            drv    = '0;
            if (in_last_q) begin
              res_d[0] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1, rejected: 1'b0};
              n        = 3'd1;
            end
          end else if (in_last_q) begin
            res_d[0] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1, rejected: 1'b1};
            n        = 3'd1;
            pos_d    = 3'd0;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end else begin
          res_d[0] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1, rejected: 1'b1};
          n        = 3'd1;
          pos_d    = 3'd0;
        end
      end
      fud_pkg::PH_DECODE: begin
        // Collect the decoded bytes this raw byte releases, in order.
        if (held_q == 2'd2) begin
          held_d = 2'd0;
          if (h[4]) begin
            fl[0] = {hd[3:0], h[3:0]};
            nf    = 2'd1;
          end else begin
            fl[0] = fud_pkg::ChPercent;
            fl[1] = digit_q;
            nf    = 2'd2;
            if (in_byte_q == fud_pkg::ChPercent) begin
              held_d = 2'd1;
            end else begin
              fl[2] = in_byte_q;
              nf    = 2'd3;
            end
          end
        end else if ((held_q == 2'd1) && h[4]) begin
          digit_d = in_byte_q;
          held_d  = 2'd2;
        end else begin
          held_d = 2'd0;
          if (held_q == 2'd1) begin
            fl[0] = fud_pkg::ChPercent;
            nf    = 2'd1;
          end
          if (in_byte_q == fud_pkg::ChPercent) begin
            held_d = 2'd1;
          end else begin
            fl[nf] = in_byte_q;
            nf     = nf + 2'd1;
          end
        end
        // An escape cut off by the end of the URI goes out literally.
        if (in_last_q) begin
          if (held_d != 2'd0) begin
            fl[nf] = fud_pkg::ChPercent;
            nf     = nf + 2'd1;
          end
          if (held_d == 2'd2) begin
            fl[nf] = digit_d;
            nf     = nf + 2'd1;
          end
          held_d = 2'd0;
        end
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < nf) begin
            fo  = fud_pkg::drv_feed(drv, fl[j]);
            drv = fo.st;
            for (int i = 0; i < 4; i++) begin
              if ((3'(i) < fo.n) && (n < 3'(fud_pkg::MaxRes))) begin
                res_d[n] = '{path_byte: fo.b[i], byte_valid: 1'b1, path_end: 1'b0,
                             rejected: 1'b0};
                n        = n + 3'd1;
              end
            end
          end
        end
        if (in_last_q) begin
          fo  = fud_pkg::drv_finish(drv);
          drv = fo.st;
          for (int i = 0; i < 4; i++) begin
            if ((3'(i) < fo.n) && (n < 3'(fud_pkg::MaxRes))) begin
              res_d[n] = '{path_byte: fo.b[i], byte_valid: 1'b1, path_end: 1'b0,
                           rejected: 1'b0};
              n        = n + 3'd1;
            end
          end
        end
        path_done = drv.zero || in_last_q;
        if (path_done) begin
          if (n == 3'd0) begin
            res_d[0] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1, rejected: 1'b0};
            n        = 3'd1;
          end else begin
            res_d[n - 3'd1].path_end = 1'b1;
          end
        end
      end
      fud_pkg::PH_DISCARD: begin
        if (in_last_q) begin
          pos_d = 3'd0;
        end
      end
      default: begin
        pos_d = 3'd0;
      end
    endcase

    drv_d = drv;
    res_n = n;
  end

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      fud_pkg::PH_PREFIX: begin
        if (!prefix_match) begin
          phase_d = in_last_q ? fud_pkg::PH_PREFIX : fud_pkg::PH_DISCARD;
        end else if ((pos_q == fud_pkg::PrefixLastPos) && !in_last_q) begin
          phase_d = fud_pkg::PH_DECODE;
        end
      end
      fud_pkg::PH_DECODE: begin
        if (path_done) begin
          phase_d = in_last_q ? fud_pkg::PH_PREFIX : fud_pkg::PH_DISCARD;
        end
      end
      fud_pkg::PH_DISCARD: begin
        if (in_last_q) begin
          phase_d = fud_pkg::PH_PREFIX;
        end
      end
      default: phase_d = fud_pkg::PH_PREFIX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= fud_pkg::PH_PREFIX;
      pos_q    <= 3'd0;
      held_q   <= 2'd0;
      drv_q    <= '0;
      cnt_q    <= 3'd0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        held_q  <= held_d;
        drv_q   <= drv_d;
        cnt_q   <= res_n;
      end else if (out_xfer) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (adv) begin
      digit_q <= digit_d;
      for (int i = 0; i < fud_pkg::MaxRes; i++) begin
        res_q[i] <= res_d[i];
      end
    end else if (out_xfer) begin
      // Move the waiting results one place toward the output.
      for (int i = 0; i < fud_pkg::MaxRes - 1; i++) begin
        res_q[i] <= res_q[i + 1];
      end
    end
  end

endmodule

FILE: hw/rtl/fud_checker.sv
// Port-level checker for the file URI decoder, bound to the top level.
`timescale 1ns / 1ps

module fud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // A rejection is a lone closing result with no byte.
  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o && !m_axis_tuser_o[0])
    else $error("malformed rejection result");

  // A result without a byte only ever closes a URI.
  a_empty_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("byteless result not marked as the end");

  // A decoded zero ends the path and is never delivered.
  a_no_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o != 8'h00)
    else $error("zero path byte delivered");

endmodule

bind file_uri_to_path_decoder fud_checker u_fud_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: verif/file_uri_to_path_decoder_test.sv
// Self-checking testbench for the file URI to path decoder, with a predicting scoreboard.
`timescale 1ns / 1ps

module file_uri_to_path_decoder_test;

  localparam int CycleLimit = 300000;
  localparam int RandomItems = 140;

  // Predicts the decoded path results from each accepted URI byte and checks the output stream.
  class path_scoreboard;
    fud_pkg::phase_e phase;
    int              prefix_pos;
    int              held_count;
    logic [7:0]      held_digit;
    logic [7:0]      lead [3];
    int              lead_count;
    bit              drive_done;
    bit              zero_seen;
    fud_pkg::res_t   step_res [fud_pkg::MaxRes];
    int              step_n;
    fud_pkg::res_t   pending [$];
    int              errors;

    function new();
      phase      = fud_pkg::PH_PREFIX;
      prefix_pos = 0;
      errors     = 0;
      foreach (lead[i]) lead[i] = 8'h00;
      open_path();
    endfunction

    function logic [7:0] scheme_at(int pos);
      string s;
      s = "file://";
      return s[pos];
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function logic [7:0] lower_of(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Returns 16 for a character that is not a hex digit.
    function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 16;
    endfunction

    function void add_result(logic [7:0] b, logic valid, logic fin, logic rej);
      if (step_n < fud_pkg::MaxRes) begin
        step_res[step_n].path_byte  = b;
        step_res[step_n].byte_valid = valid;
        step_res[step_n].path_end   = fin;
        step_res[step_n].rejected   = rej;
        step_n++;
      end
    endfunction

    function void put_path_byte(logic [7:0] b);
      add_result(b, 1'b1, 1'b0, 1'b0);
    endfunction

    function void flush_lead();
      for (int i = 0; i < lead_count; i++) put_path_byte(lead[i]);
      lead_count = 0;
    endfunction

    // Makes the drive-letter decision once the path ends.
    function void settle_drive();
      if (drive_done) return;
      if (lead_count == 3) begin
        put_path_byte(lower_of(lead[1]));
        put_path_byte(":");
        lead_count = 0;
      end else begin
        flush_lead();
      end
      drive_done = 1'b1;
    endfunction

    function void feed_path(logic [7:0] d);
      bit ok;
      if (zero_seen) return;
      if (d == 8'h00) begin
        zero_seen = 1'b1;
        settle_drive();
        return;
      end
      if (drive_done) begin
        put_path_byte(d);
        return;
      end
      if (lead_count == 3) begin
        if (d == fud_pkg::ChSlash) begin
          put_path_byte(lower_of(lead[1]));
          put_path_byte(":");
        end else begin
          put_path_byte("/");
          put_path_byte(lead[1]);
          put_path_byte(":");
        end
        put_path_byte(d);
        lead_count = 0;
        drive_done = 1'b1;
        return;
      end
      ok = (lead_count == 0 && d == fud_pkg::ChSlash) || (lead_count == 1 && is_alpha(d)) ||
           (lead_count == 2 && d == fud_pkg::ChColon);
      if (ok) begin
        lead[lead_count] = d;
        lead_count++;
        return;
      end
      flush_lead();
      put_path_byte(d);
      drive_done = 1'b1;
    endfunction

    function void take_fresh(logic [7:0] c);
      if (c == fud_pkg::ChPercent) held_count = 1;
      else feed_path(c);
    endfunction

    function void take_raw(logic [7:0] c);
      int h;
      h = digit_value(c);
      if (held_count == 1) begin
        if (h < 16) begin
          held_digit = c;
          held_count = 2;
        end else begin
          held_count = 0;
          feed_path(fud_pkg::ChPercent);
          take_fresh(c);
        end
      end else if (held_count == 2) begin
        held_count = 0;
        if (h < 16) begin
          feed_path(8'((digit_value(held_digit) << 4) | h));
        end else begin
          feed_path(fud_pkg::ChPercent);
          feed_path(held_digit);
          take_fresh(c);
        end
      end else begin
        take_fresh(c);
      end
    endfunction

    function void open_path();
      held_count = 0;
      held_digit = 8'h00;
      lead_count = 0;
      drive_done = 1'b0;
      zero_seen  = 1'b0;
    endfunction

    function void close_path();
      if (step_n == 0) add_result(8'h00, 1'b0, 1'b1, 1'b0);
      else step_res[step_n-1].path_end = 1'b1;
    endfunction

    function void note_input(logic [7:0] b, logic fin);
      step_n = 0;
      case (phase)
        fud_pkg::PH_PREFIX: begin
          if (b == scheme_at(prefix_pos)) begin
            prefix_pos++;
            if (prefix_pos == 7) begin
              prefix_pos = 0;
              open_path();
              if (fin) close_path();
              else phase = fud_pkg::PH_DECODE;
            end else if (fin) begin
              add_result(8'h00, 1'b0, 1'b1, 1'b1);
              prefix_pos = 0;
            end
          end else begin
            add_result(8'h00, 1'b0, 1'b1, 1'b1);
            prefix_pos = 0;
            phase = fin ? fud_pkg::PH_PREFIX : fud_pkg::PH_DISCARD;
          end
        end
        fud_pkg::PH_DECODE: begin
          take_raw(b);
          // An escape cut short by the end of the URI goes out literally.
          if (!zero_seen && fin) begin
            if (held_count >= 1) feed_path(fud_pkg::ChPercent);
            if (held_count == 2) feed_path(held_digit);
            held_count = 0;
            settle_drive();
          end
          if (zero_seen || fin) begin
            close_path();
            phase = fin ? fud_pkg::PH_PREFIX : fud_pkg::PH_DISCARD;
          end
        end
        default: begin
          if (fin) begin
            phase      = fud_pkg::PH_PREFIX;
            prefix_pos = 0;
          end
        end
      endcase
      for (int i = 0; i < step_n; i++) pending.push_back(step_res[i]);
    endfunction

    function void check_result(fud_pkg::res_t got);
      fud_pkg::res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %h/%b/%b/%b", $realtime, got.path_byte,
                 got.byte_valid, got.path_end, got.rejected);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.path_byte !== exp_r.path_byte) begin
        $display("%0t: path_byte expected %h actual %h", $realtime, exp_r.path_byte,
                 got.path_byte);
        errors++;
      end
      if (got.byte_valid !== exp_r.byte_valid) begin
        $display("%0t: byte_valid expected %b actual %b", $realtime, exp_r.byte_valid,
                 got.byte_valid);
        errors++;
      end
      if (got.path_end !== exp_r.path_end) begin
        $display("%0t: path_end expected %b actual %b", $realtime, exp_r.path_end,
                 got.path_end);
        errors++;
      end
      if (got.rejected !== exp_r.rejected) begin
        $display("%0t: rejected expected %b actual %b", $realtime, exp_r.rejected,
                 got.rejected);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic       m_axis_tlast_o;

  path_scoreboard sb = new();
  logic [7:0]     uri_bytes [$];
  int             items_sent = 0;
  int             cycles = 0;
  int             stall_left = 0;
  bit             quiet = 1'b0;
  bit             drained_once = 1'b0;

  file_uri_to_path_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output backpressure in random bursts, off during the final stretch.
  always @(posedge clk_i) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 13);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fud_pkg::res_t got;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      got.path_byte  = m_axis_tdata_o;
      got.byte_valid = m_axis_tuser_o[0];
      got.rejected   = m_axis_tuser_o[1];
      got.path_end   = m_axis_tlast_o;
      sb.check_result(got);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic fin);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(b, fin);
    items_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) uri_bytes.push_back(s[i]);
  endtask

  task automatic send_uri();
    foreach (uri_bytes[i]) send_item(uri_bytes[i], i == uri_bytes.size() - 1);
    uri_bytes.delete();
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return "0" + v;
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  task automatic add_escape(input logic [7:0] v);
    uri_bytes.push_back(fud_pkg::ChPercent);
    uri_bytes.push_back(hex_char(v[7:4]));
    uri_bytes.push_back(hex_char(v[3:0]));
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
  endfunction

  // Mostly well-formed file URIs with random paths; some bad or cut-short prefixes.
  task automatic build_random_uri();
    int kind;
    int chunks;
    int c;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      add_text("file://");
      uri_bytes[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
    end else if (kind < 15) begin
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++) uri_bytes.push_back(sb.scheme_at(i));
      return;
    end else begin
      add_text("file://");
    end
    case ($urandom_range(0, 4))
      0: begin
        uri_bytes.push_back("/");
        uri_bytes.push_back(rand_letter());
        uri_bytes.push_back(":");
      end
      1: begin
        uri_bytes.push_back("/");
        uri_bytes.push_back(rand_letter());
        uri_bytes.push_back(":");
        uri_bytes.push_back("/");
      end
      2: begin
        add_escape(fud_pkg::ChSlash);
        uri_bytes.push_back(rand_letter());
        add_escape(fud_pkg::ChColon);
      end
      3: uri_bytes.push_back("/");
      default: ;
    endcase
    chunks = $urandom_range(0, 6);
    for (int i = 0; i < chunks; i++) begin
      c = $urandom_range(0, 19);
      if (c < 4) begin
        uri_bytes.push_back(rand_letter());
      end else if (c < 6) begin
        uri_bytes.push_back("/");
      end else if (c == 6) begin
        uri_bytes.push_back(":");
      end else if (c < 10) begin
        add_escape(8'($urandom_range(1, 255)));
      end else if (c == 10) begin
        add_escape($urandom_range(0, 1) ? fud_pkg::ChSlash : fud_pkg::ChColon);
      end else if (c == 11) begin
        // Broken escape: a non-hex character where a digit belongs.
        uri_bytes.push_back(fud_pkg::ChPercent);
        if ($urandom_range(0, 1)) uri_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
        uri_bytes.push_back($urandom_range(0, 2) == 0 ? fud_pkg::ChPercent : 8'h67);
      end else if (c == 12) begin
        uri_bytes.push_back(fud_pkg::ChPercent);
      end else if (c == 13) begin
        uri_bytes.push_back(fud_pkg::ChPercent);
        uri_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      end else if (c == 14 && $urandom_range(0, 3) == 0) begin
        add_escape(8'h00);
      end else begin
        uri_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (uri_bytes.size() == 0) uri_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int start_count;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    add_text("x");
    send_uri();
    add_text("fil");
    send_uri();
    add_text("ftp://a");
    send_uri();
    add_text("file://");
    send_uri();
    add_text("file:///C:");
    send_uri();
    add_text("file:///q:/%41%4g%zZ/%2f%");
    send_uri();
    add_text("file://%2Fb%3A%4");
    send_uri();
    add_text("file:///");
    uri_bytes.push_back(8'hFF);
    add_text("%00");
    uri_bytes.push_back(8'h80);
    send_uri();
    add_text("file://a");
    uri_bytes.push_back(8'h00);
    add_text("z");
    send_uri();

    start_count = items_sent;
    while (items_sent < start_count + RandomItems) begin
      if (items_sent > start_count + RandomItems - 40) quiet = 1'b1;
      // Let the output drain completely once before carrying on.
      if (!drained_once && items_sent > start_count + RandomItems / 2) begin
        drained_once = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      build_random_uri();
      send_uri();
    end

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fud_pkg.sv
hw/rtl/file_uri_to_path_decoder.sv
hw/rtl/fud_checker.sv
verif/file_uri_to_path_decoder_test.sv
